/* design/contour_segment_normal_offset_assert.svh */
// ----------------------------------------------------------------------------
// Contour segment normal offset: assertion macros
// Concurrent assertion forms used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef CONTOUR_SEGMENT_NORMAL_OFFSET_ASSERT_SVH
`define CONTOUR_SEGMENT_NORMAL_OFFSET_ASSERT_SVH

// same-cycle implication
`define CSNO_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSNO_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/csno_pkg.sv */
// ----------------------------------------------------------------------------
// Contour segment normal offset: package
// Widths and beat types shared by the sequencer and its iterative units.
// ----------------------------------------------------------------------------
package csno_pkg;

  localparam int COORD_W   = 32;
  localparam int OFS_W     = 24;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SUM_W     = COORD_W + 3;
  localparam int NORM_LOW  = 29;
  localparam int MAG_W     = NORM_LOW + 1;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int RAD_W     = PROD_W + 2;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int QUO_W     = OFS_W + 2;
  localparam int NUM_W     = OFS_W + MAG_W + 2;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int CNT_W     = 5;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      starts_contour;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] offset_x;
    logic signed [COORD_W-1:0] offset_y;
  } out_t;

endpackage

/* design/csno_isqrt.sv */
// ----------------------------------------------------------------------------
// Contour segment normal offset: integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module csno_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [csno_pkg::RAD_W-1:0]    rad_i,
  output logic [csno_pkg::ROOT_W-1:0]   root_o,
  output logic                          done_o
);
  import csno_pkg::*;

  localparam int TRIAL_W = REM_W + 3;

  logic [RAD_W-1:0]   rad_q,  rad_d;
  logic [REM_W-1:0]   rem_q,  rem_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic [CNT_W-1:0]   cnt_q,  cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [TRIAL_W-1:0] trial;

  assign trial = TRIAL_W'({rem_q, rad_q[RAD_W-1 -: 2]}) - TRIAL_W'({root_q, 2'b01});

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(ROOT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[RAD_W-3:0], 2'b00};
      if (!trial[TRIAL_W-1]) begin
        rem_d  = trial[REM_W-1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'({rem_q, rad_q[RAD_W-1 -: 2]});
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

/* design/csno_div.sv */
// ----------------------------------------------------------------------------
// Contour segment normal offset: restoring divider
// Unsigned division, one quotient bit per cycle; the quotient is known to fit.
// ----------------------------------------------------------------------------
module csno_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [csno_pkg::NUM_W-1:0]   num_i,
  input  logic [csno_pkg::DEN_W-1:0]   den_i,
  output logic [csno_pkg::QUO_W-1:0]   quot_o,
  output logic                         done_o
);
  import csno_pkg::*;

  localparam int TRIAL_W = DEN_W + 2;

  logic [DEN_W-1:0]   den_q,  den_d;
  logic [DEN_W-1:0]   rem_q,  rem_d;
  logic [QUO_W-1:0]   low_q,  low_d;
  logic [CNT_W-1:0]   cnt_q,  cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [TRIAL_W-1:0] trial;

  assign trial = TRIAL_W'({rem_q, low_q[QUO_W-1]}) - TRIAL_W'(den_q);

  always_comb begin
    den_d  = den_q;
    rem_d  = rem_q;
    low_d  = low_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      den_d  = den_i;
      rem_d  = DEN_W'(num_i[NUM_W-1:QUO_W]);
      low_d  = num_i[QUO_W-1:0];
      cnt_d  = CNT_W'(QUO_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[TRIAL_W-1]) begin
        rem_d = trial[DEN_W-1:0];
        low_d = {low_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DEN_W-2:0], low_q[QUO_W-1]};
        low_d = {low_q[QUO_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    low_q <= low_d;
  end

  assign quot_o = low_q;
  assign done_o = done_q;

endmodule

/* design/contour_segment_normal_offset.sv */
// Segment point: magnitudes are normalised by 0 to 29 shifts before the square root.
// One segment point at a time; the next is taken when the result sits in the output register.
// Each segment passes the 31-step square root and two 26-step passes through one divider.
// Contour-start points only load the stored point; zero-length segments return to idle unprocessed.
// Reset clears the offset distance, the stored-point flag and both handshakes.
// ----------------------------------------------------------------------------
// Contour segment normal offset: top level
// Sequencer around one multiplier, a square root unit and a divider that
// offsets each segment midpoint along its unit normal.
// ----------------------------------------------------------------------------
`include "contour_segment_normal_offset_assert.svh"

module contour_segment_normal_offset (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic signed [csno_pkg::OFS_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  csno_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output csno_pkg::out_t                  out_data_o
);
  import csno_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_ABS   = 13'b0000000000010,
    S_NORM  = 13'b0000000000100,
    S_SQX   = 13'b0000000001000,
    S_SQY   = 13'b0000000010000,
    S_SUM   = 13'b0000000100000,
    S_ROOT  = 13'b0000001000000,
    S_RWAIT = 13'b0000010000000,
    S_MUL   = 13'b0000100000000,
    S_NUM   = 13'b0001000000000,
    S_DIV   = 13'b0010000000000,
    S_DWAIT = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_e;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2**(COORD_W-1) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  function automatic logic signed [COORD_W-1:0] finish(input logic signed [SUM_W-1:0] h);
    logic signed [SUM_W-1:0] q;
    q = h >>> 1;
    if (q > SAT_HI) begin
      q = SAT_HI;
    end else if (q < SAT_LO) begin
      q = SAT_LO;
    end
    return q[COORD_W-1:0];
  endfunction

  state_e                    state_q, state_d;
  logic                      have_prior_q, have_prior_d;
  logic [OFS_W-1:0]          ad_q;
  logic                      ofs_neg_q;
  logic signed [COORD_W-1:0] prior_x_q, prior_x_d, prior_y_q, prior_y_d;
  logic signed [DIFF_W-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic [DIFF_W-1:0]         ax_q, ax_d, ay_q, ay_d;
  logic                      sx_q, sx_d, sy_q, sy_d;
  logic signed [SUM_W-1:0]   hx_q, hx_d, hy_q, hy_d;
  logic [PROD_W-1:0]         prod_q, prod_d;
  logic [ACC_W-1:0]          acc_q, acc_d;
  logic [ROOT_W-1:0]         len_q, len_d;
  logic [NUM_W-1:0]          num_q, num_d;
  logic                      sel_q, sel_d;
  out_t                      out_q, out_d;
  logic                      out_valid_q, out_valid_d;

  logic                      in_take;
  logic                      fin_go;
  logic [MAG_W-1:0]          op_a, op_b;
  logic [PROD_W-1:0]         mul;
  logic                      sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]         sqrt_root;
  logic                      div_start, div_done;
  logic [QUO_W-1:0]          div_quot;
  logic [DIFF_W-1:0]         ab_or;
  logic signed [SUM_W-1:0]   cmag, comp, hsel, hnew;
  logic                      cneg;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign fin_go     = !out_valid_q || !out_stall_i;
  assign ab_or      = ax_q | ay_q;

  // shared multiplier
  always_comb begin
    case (state_q)
      S_SQX:   op_a = ax_q[MAG_W-1:0];
      S_SQY:   op_a = ay_q[MAG_W-1:0];
      default: op_a = sel_q ? ax_q[MAG_W-1:0] : ay_q[MAG_W-1:0];
    endcase
    op_b = (state_q == S_SQX || state_q == S_SQY) ? op_a : MAG_W'(ad_q);
  end
  assign mul = op_a * op_b;

  assign sqrt_start = (state_q == S_ROOT);
  assign div_start  = (state_q == S_DIV);

  assign cmag = signed'(SUM_W'(div_quot));
  assign cneg = sel_q ? !(ofs_neg_q ^ sx_q) : (ofs_neg_q ^ sy_q);
  assign comp = cneg ? -cmag : cmag;
  assign hsel = sel_q ? hy_q : hx_q;
  assign hnew = hsel + comp + SUM_W'(1);

  always_comb begin
    state_d      = state_q;
    have_prior_d = have_prior_q;
    prior_x_d    = prior_x_q;
    prior_y_d    = prior_y_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    ax_d         = ax_q;
    ay_d         = ay_q;
    sx_d         = sx_q;
    sy_d         = sy_q;
    hx_d         = hx_q;
    hy_d         = hy_q;
    prod_d       = prod_q;
    acc_d        = acc_q;
    len_d        = len_q;
    num_d        = num_q;
    sel_d        = sel_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          prior_x_d    = in_data_i.point_x;
          prior_y_d    = in_data_i.point_y;
          have_prior_d = 1'b1;
          if (have_prior_q && !in_data_i.starts_contour) begin
            dx_d    = DIFF_W'(in_data_i.point_x) - DIFF_W'(prior_x_q);
            dy_d    = DIFF_W'(in_data_i.point_y) - DIFF_W'(prior_y_q);
            hx_d    = SUM_W'(in_data_i.point_x) + SUM_W'(prior_x_q);
            hy_d    = SUM_W'(in_data_i.point_y) + SUM_W'(prior_y_q);
            state_d = S_ABS;
          end
        end
      end
      S_ABS: begin
        ax_d = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
        ay_d = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);
        sx_d = dx_q[DIFF_W-1];
        sy_d = dy_q[DIFF_W-1];
        if (dx_q == '0 && dy_q == '0) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (ab_or[DIFF_W-1:MAG_W] != '0) begin
          ax_d = ax_q >> 1;
          ay_d = ay_q >> 1;
        end else if (!ab_or[NORM_LOW]) begin
          ax_d = ax_q << 1;
          ay_d = ay_q << 1;
        end else begin
          state_d = S_SQX;
        end
      end
      S_SQX: begin
        prod_d  = mul;
        state_d = S_SQY;
      end
      S_SQY: begin
        prod_d  = mul;
        acc_d   = ACC_W'(prod_q);
        state_d = S_SUM;
      end
      S_SUM: begin
        acc_d   = acc_q + ACC_W'(prod_q);
        state_d = S_ROOT;
      end
      S_ROOT: begin
        state_d = S_RWAIT;
      end
      S_RWAIT: begin
        if (sqrt_done) begin
          len_d   = sqrt_root;
          sel_d   = 1'b0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = mul;
        state_d = S_NUM;
      end
      S_NUM: begin
        num_d   = {prod_q[NUM_W-3:0], 2'b00} + NUM_W'(len_q);
        state_d = S_DIV;
      end
      S_DIV: begin
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          if (sel_q) begin
            hy_d    = hnew;
            state_d = S_FIN;
          end else begin
            hx_d    = hnew;
            sel_d   = 1'b1;
            state_d = S_MUL;
          end
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_d.offset_x = finish(hx_q);
          out_d.offset_y = finish(hy_q);
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      have_prior_q <= 1'b0;
      out_valid_q  <= 1'b0;
      ad_q         <= '0;
      ofs_neg_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      have_prior_q <= have_prior_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        ad_q      <= cfg_wdata_i[OFS_W-1] ? OFS_W'(-cfg_wdata_i) : OFS_W'(cfg_wdata_i);
        ofs_neg_q <= cfg_wdata_i[OFS_W-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prior_x_q <= prior_x_d;
    prior_y_q <= prior_y_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    ax_q      <= ax_d;
    ay_q      <= ay_d;
    sx_q      <= sx_d;
    sy_q      <= sy_d;
    hx_q      <= hx_d;
    hy_q      <= hy_d;
    prod_q    <= prod_d;
    acc_q     <= acc_d;
    len_q     <= len_d;
    num_q     <= num_d;
    sel_q     <= sel_d;
    out_q     <= out_d;
  end

  csno_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (RAD_W'(acc_q)),
    .root_o  (sqrt_root),
    .done_o  (sqrt_done)
  );

  csno_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   ({len_q, 1'b0}),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CSNO_ASSERT_NXT(a_start_loads_only, clk_i, rst_ni,
    in_take && (in_data_i.starts_contour || !have_prior_q),
    state_q == S_IDLE && have_prior_q, "contour start point left idle")
  `CSNO_ASSERT_IMP(a_norm_range, clk_i, rst_ni, state_q == S_SQX,
    ab_or[DIFF_W-1:MAG_W] == '0 && ab_or[NORM_LOW], "magnitudes not normalised")
  `CSNO_ASSERT_IMP(a_root_range, clk_i, rst_ni, sqrt_done,
    state_q == S_RWAIT && sqrt_root[ROOT_W-1:NORM_LOW] != '0, "square root out of step")
  `CSNO_ASSERT_IMP(a_div_owner, clk_i, rst_ni, div_done,
    state_q == S_DWAIT, "divider finished outside its wait")
  `CSNO_ASSERT_IMP(a_out_from_fin, clk_i, rst_ni, $rose(out_valid_q),
    $past(state_q) == S_FIN, "result beat not from final step")

endmodule
